/* hdl/lts_pkg.sv */
// Shared types, constants and character-class helpers for the lexical token scanner.
// Used by lts_scanner, lts_drain, lexical_token_scanner_unit and its testbench.
// No dependencies.
package lts_pkg;

    localparam int MAX_TOKEN  = 32;
    localparam int ADDR_W     = $clog2(MAX_TOKEN);
    localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
    localparam int CHAR_W     = 8;
    localparam int NUM_KW     = 8;
    localparam int KWI_W      = 3;
    localparam int KW_MAX_LEN = 5;
    localparam int KW_POS_W   = 3;
    localparam int TDATA_W    = 16;
    localparam int TUSER_W    = 6;

    typedef enum logic [2:0] {
        K_IDENT   = 3'd0,
        K_KEYWORD = 3'd1,
        K_NUMBER  = 3'd2,
        K_DELIM   = 3'd3,
        K_ERROR   = 3'd4
    } kind_t;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_EQ    = "=";
    localparam logic [CHAR_W-1:0] CH_SLASH = "/";
    localparam logic [CHAR_W-1:0] CH_STAR  = "*";

    // Keyword spellings, first character at position 0, zero filled
    localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e"},
        '{"d", "o", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00},
        '{"r", "e", "a", "d", 8'h00},
        '{"w", "r", "i", "t", "e"}
    };

    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        LEN_W'(2), LEN_W'(4), LEN_W'(3), LEN_W'(5),
        LEN_W'(2), LEN_W'(3), LEN_W'(4), LEN_W'(5)
    };

    // One RAM write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } ram_wr_t;

    // Everything one accepted item asks the output side to send
    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        kind_t             word_kind;
        logic [KWI_W-1:0]  kwi;
        logic              trunc;
        logic              word_es;
        logic [1:0]        ex_cnt;
        logic [CHAR_W-1:0] ex0_char;
        kind_t             ex0_kind;
        logic              ex0_last;
        logic              ex0_es;
        logic [CHAR_W-1:0] ex1_char;
        kind_t             ex1_kind;
        logic              ex1_es;
        logic              defer;
        logic [CHAR_W-1:0] defer_char;
    } emit_req_t;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_NL || c == CH_TAB;
    endfunction

    function automatic logic is_single(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            "+", "-", "*", "(", ")", "{", "}", ";", ",", ":": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_double_first(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            ">", "<", "=", "!": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Character of keyword k at position pos, zero past its end
    function automatic logic [CHAR_W-1:0] kw_char(input logic [KWI_W-1:0] k,
                                                  input logic [LEN_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (pos < KW_LEN[k]) begin
            ch = KW_TEXT[k][pos[KW_POS_W-1:0]];
        end
        return ch;
    endfunction

endpackage

/* hdl/lts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read; read data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lts_scanner.sv */
// Scan state machine: classifies each accepted byte, appends token text to the
// token RAM and builds the emit request for lts_drain. Depends on lts_pkg.
module lts_scanner
    import lts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              end_of_input,
    output ram_wr_t           wr,
    output emit_req_t         req
);

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_IDENT   = 7'b0000010,
        M_NUMBER  = 7'b0000100,
        M_DOUBLE  = 7'b0001000,
        M_SLASH   = 7'b0010000,
        M_COMMENT = 7'b0100000,
        M_CSTAR   = 7'b1000000
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [CHAR_W-1:0]  pend_reg, pend_next;
    logic               sticky_reg, sticky_next;
    logic [NUM_KW-1:0]  kwm_reg, kwm_next;

    logic               fall;
    logic               extend;
    logic               start;
    logic               em_valid;
    logic [CHAR_W-1:0]  em_char;
    kind_t              em_kind;
    logic               kw_hit;
    logic [KWI_W-1:0]   kw_idx;

    // Match the buffered word against the keyword list
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (kwm_reg[k] && KW_LEN[k] == len_reg) begin
                kw_hit = 1'b1;
                kw_idx = KWI_W'(k);
            end
        end
    end

    // Next scan state and emit request for one byte
    always_comb begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        sticky_next = sticky_reg;
        kwm_next    = kwm_reg;
        wr          = '0;
        fall        = 1'b0;
        extend      = 1'b0;
        start       = 1'b0;
        em_valid    = 1'b0;
        em_char     = char_in;
        em_kind     = K_DELIM;

        req            = '0;
        req.len        = len_reg;
        req.trunc      = ovf_reg;
        req.word_es    = sticky_reg;
        req.word_kind  = (mode_reg == M_NUMBER) ? K_NUMBER : K_IDENT;
        req.kwi        = '0;
        req.ex0_kind   = K_DELIM;
        req.ex1_kind   = K_DELIM;
        req.defer_char = char_in;
        if (mode_reg == M_IDENT && !ovf_reg && kw_hit) begin
            req.word_kind = K_KEYWORD;
            req.kwi       = kw_idx;
        end

        if (accept) begin
            if (end_of_input) begin
                // Flush whatever is pending and return to idle
                unique case (mode_reg)
                    M_IDENT, M_NUMBER: req.flush = 1'b1;
                    M_DOUBLE: begin
                        req.ex_cnt   = 2'd1;
                        req.ex0_char = pend_reg;
                        req.ex0_last = 1'b1;
                        req.ex0_es   = sticky_reg;
                    end
                    M_SLASH: begin
                        req.ex_cnt   = 2'd1;
                        req.ex0_char = CH_SLASH;
                        req.ex0_last = 1'b1;
                        req.ex0_es   = sticky_reg;
                    end
                    default: ;
                endcase
                mode_next = M_IDLE;
                len_next  = '0;
                ovf_next  = 1'b0;
            end else begin
                unique case (mode_reg)
                    M_IDENT: begin
                        if (is_alpha(char_in) || is_digit(char_in)) begin
                            extend = 1'b1;
                        end else begin
                            req.flush = 1'b1;
                            fall      = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(char_in)) begin
                            extend = 1'b1;
                        end else begin
                            req.flush = 1'b1;
                            fall      = 1'b1;
                        end
                    end
                    M_DOUBLE: begin
                        req.ex_cnt   = 2'd1;
                        req.ex0_char = pend_reg;
                        req.ex0_last = 1'b1;
                        req.ex0_es   = sticky_reg;
                        if (char_in == CH_EQ) begin
                            req.ex_cnt   = 2'd2;
                            req.ex0_last = 1'b0;
                            req.ex1_char = CH_EQ;
                            req.ex1_es   = sticky_reg;
                            mode_next    = M_IDLE;
                        end else begin
                            fall = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (char_in == CH_STAR) begin
                            mode_next = M_COMMENT;
                        end else begin
                            req.ex_cnt   = 2'd1;
                            req.ex0_char = CH_SLASH;
                            req.ex0_last = 1'b1;
                            req.ex0_es   = sticky_reg;
                            fall         = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (char_in == CH_STAR) begin
                            mode_next = M_CSTAR;
                        end
                    end
                    M_CSTAR: begin
                        if (char_in == CH_SLASH) begin
                            mode_next = M_IDLE;
                        end else if (char_in != CH_STAR) begin
                            mode_next = M_COMMENT;
                        end
                    end
                    M_IDLE: fall = 1'b1;
                    default: fall = 1'b1;
                endcase
            end
        end

        // Append to the current word, or mark it cut
        if (extend) begin
            if (len_reg < LEN_W'(MAX_TOKEN)) begin
                wr.en    = 1'b1;
                wr.addr  = len_reg[ADDR_W-1:0];
                wr.data  = char_in;
                len_next = len_reg + LEN_W'(1);
                for (int k = 0; k < NUM_KW; k++) begin
                    kwm_next[k] = kwm_reg[k] && (kw_char(KWI_W'(k), len_reg) == char_in);
                end
            end else begin
                ovf_next = 1'b1;
            end
        end

        // Scan the byte as the start of a new token
        if (fall) begin
            mode_next = M_IDLE;
            len_next  = '0;
            ovf_next  = 1'b0;
            if (is_space(char_in)) begin
                mode_next = M_IDLE;
            end else if (is_alpha(char_in)) begin
                start     = 1'b1;
                mode_next = M_IDENT;
                for (int k = 0; k < NUM_KW; k++) begin
                    kwm_next[k] = (kw_char(KWI_W'(k), LEN_W'(0)) == char_in);
                end
            end else if (is_digit(char_in)) begin
                start     = 1'b1;
                mode_next = M_NUMBER;
                kwm_next  = '0;
            end else if (is_single(char_in)) begin
                em_valid = 1'b1;
            end else if (is_double_first(char_in)) begin
                pend_next = char_in;
                mode_next = M_DOUBLE;
            end else if (char_in == CH_SLASH) begin
                mode_next = M_SLASH;
            end else begin
                sticky_next = 1'b1;
                em_valid    = 1'b1;
                em_kind     = K_ERROR;
            end
        end

        // First character of a new token: hold it while a flushed word drains
        if (start) begin
            len_next = LEN_W'(1);
            if (req.flush) begin
                req.defer = 1'b1;
            end else begin
                wr.en   = 1'b1;
                wr.addr = '0;
                wr.data = char_in;
            end
        end

        // Queue a single-character token behind any earlier one
        if (em_valid) begin
            if (req.ex_cnt == 2'd0) begin
                req.ex0_char = em_char;
                req.ex0_kind = em_kind;
                req.ex0_last = 1'b1;
                req.ex0_es   = sticky_next;
            end else begin
                req.ex1_char = em_char;
                req.ex1_kind = em_kind;
                req.ex1_es   = sticky_next;
            end
            req.ex_cnt = req.ex_cnt + 2'd1;
        end
    end

    // Scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            pend_reg   <= '0;
            sticky_reg <= 1'b0;
            kwm_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            pend_reg   <= pend_next;
            sticky_reg <= sticky_next;
            kwm_reg    <= kwm_next;
        end
    end

endmodule

/* hdl/lts_drain.sv */
// Output sequencer: reads a flushed word out of the token RAM one character per
// cycle while the output pipe has room, appends single-character tokens, and
// drives the result channel. Depends on lts_pkg.
module lts_drain
    import lts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               go,
    input  emit_req_t          req,
    output logic               busy,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [CHAR_W-1:0]  rd_data,
    output ram_wr_t            wr,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // token_char, truncated, error_seen, zero fill
    output logic [TUSER_W-1:0] m_tuser,   // kind, keyword_index
    output logic               m_tlast
);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_WORD  = 5'b00010,
        D_EX0   = 5'b00100,
        D_EX1   = 5'b01000,
        D_WRITE = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [KWI_W-1:0]  kwi;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              trunc;
        logic              es;
    } item_t;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    emit_req_t         req_reg;
    logic              s1_valid_reg;
    logic              s1_from_ram_reg;
    item_t             s1_item_reg;
    logic              m_valid_reg;
    item_t             m_item_reg;

    logic              move;
    logic              can_issue;
    logic              issue;
    logic              issue_from_ram;
    item_t             issue_item;
    item_t             s1_resolved;
    logic              word_last;

    assign move      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign can_issue = !s1_valid_reg || move;
    assign busy      = (phase_reg != D_IDLE);
    assign word_last = (idx_reg + LEN_W'(1)) == req_reg.len;

    // Issue one item per cycle while the pipe has room
    always_comb begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        issue          = 1'b0;
        issue_from_ram = 1'b0;
        issue_item     = '0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        wr             = '0;
        unique case (phase_reg)
            D_IDLE: begin
                if (go) begin
                    idx_next = '0;
                    if (req.flush) begin
                        phase_next = D_WORD;
                    end else if (req.ex_cnt != 2'd0) begin
                        phase_next = D_EX0;
                    end
                end
            end
            D_WORD: begin
                if (can_issue) begin
                    issue            = 1'b1;
                    issue_from_ram   = 1'b1;
                    rd_en            = 1'b1;
                    issue_item.kind  = req_reg.word_kind;
                    issue_item.kwi   = req_reg.kwi;
                    issue_item.last  = word_last;
                    issue_item.trunc = req_reg.trunc;
                    issue_item.es    = req_reg.word_es;
                    idx_next         = idx_reg + LEN_W'(1);
                    if (word_last) begin
                        if (req_reg.ex_cnt != 2'd0) begin
                            phase_next = D_EX0;
                        end else if (req_reg.defer) begin
                            phase_next = D_WRITE;
                        end else begin
                            phase_next = D_IDLE;
                        end
                    end
                end
            end
            D_EX0: begin
                if (can_issue) begin
                    issue           = 1'b1;
                    issue_item.kind = req_reg.ex0_kind;
                    issue_item.ch   = req_reg.ex0_char;
                    issue_item.last = req_reg.ex0_last;
                    issue_item.es   = req_reg.ex0_es;
                    if (req_reg.ex_cnt == 2'd2) begin
                        phase_next = D_EX1;
                    end else if (req_reg.defer) begin
                        phase_next = D_WRITE;
                    end else begin
                        phase_next = D_IDLE;
                    end
                end
            end
            D_EX1: begin
                if (can_issue) begin
                    issue           = 1'b1;
                    issue_item.kind = req_reg.ex1_kind;
                    issue_item.ch   = req_reg.ex1_char;
                    issue_item.last = 1'b1;
                    issue_item.es   = req_reg.ex1_es;
                    phase_next      = req_reg.defer ? D_WRITE : D_IDLE;
                end
            end
            D_WRITE: begin
                // Store the held first character of the next token
                wr.en      = 1'b1;
                wr.addr    = '0;
                wr.data    = req_reg.defer_char;
                phase_next = D_IDLE;
            end
            default: phase_next = D_IDLE;
        endcase
    end

    // Take the character from the RAM for word items
    always_comb begin
        s1_resolved = s1_item_reg;
        if (s1_from_ram_reg) begin
            s1_resolved.ch = rd_data;
        end
    end

    // Sequencer and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= D_IDLE;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            if (can_issue) begin
                s1_valid_reg <= issue;
            end
            if (!m_valid_reg || m_tready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (go && phase_reg == D_IDLE) begin
            req_reg <= req;
        end
        if (issue) begin
            s1_item_reg     <= issue_item;
            s1_from_ram_reg <= issue_from_ram;
        end
        if (move) begin
            m_item_reg <= s1_resolved;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - CHAR_W - 2){1'b0}}, m_item_reg.es, m_item_reg.trunc,
                       m_item_reg.ch};
    assign m_tuser  = {m_item_reg.kwi, m_item_reg.kind};
    assign m_tlast  = m_item_reg.last;

endmodule

/* hdl/lexical_token_scanner_unit.sv */
// Lexical token scanner: byte stream in, tagged token characters out.
// Input s_tdata[7:0] is a source byte; s_tlast marks end of text (byte ignored).
// Output: one item per token character. m_tdata holds token_char [7:0],
// truncated [8], error_seen [9]; m_tuser holds kind [2:0], keyword_index [5:3];
// m_tlast is set on the final character of each token.
// Bytes that finish no token are taken every cycle. A byte that finishes
// tokens holds s_tready low while their characters are issued, and while the
// first character of a new word that starts directly after the flushed one
// is written to the token RAM; the single read port of the token RAM sets this.
// The first result passes the drain phase, s1 and output registers before m_tvalid.
// Results queue in a two-stage output pipe; when m_tready is low the pipe
// fills, the drain stops issuing and s_tready stays low until the rest of
// the current token has entered the pipe.
// Reset (aresetn low, synchronous) clears scan state, the sticky error flag
// and the output pipe; the token RAM needs no clearing.
// Depends on lts_pkg, lts_ram, lts_scanner and lts_drain.
module lexical_token_scanner_unit
    import lts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // char_in
    input  logic               s_tlast,   // end_of_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // token_char, truncated, error_seen, zero fill
    output logic [TUSER_W-1:0] m_tuser,   // kind, keyword_index
    output logic               m_tlast
);

    logic              accept;
    logic              drain_busy;
    ram_wr_t           scan_wr;
    ram_wr_t           drain_wr;
    ram_wr_t           ram_wr;
    emit_req_t         req;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CHAR_W-1:0] ram_rd_data;

    // Take a byte only when no earlier token is still being read out
    assign s_tready = !drain_busy;
    assign accept   = s_tvalid && s_tready;

    // Scanner writes only on accept, drain only while busy
    assign ram_wr = scan_wr.en ? scan_wr : drain_wr;

    lts_scanner u_scanner (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_in      (s_tdata),
        .end_of_input (s_tlast),
        .wr           (scan_wr),
        .req          (req)
    );

    lts_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_TOKEN)
    ) u_token_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lts_drain u_drain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (accept),
        .req      (req),
        .busy     (drain_busy),
        .rd_en    (ram_rd_en),
        .rd_addr  (ram_rd_addr),
        .rd_data  (ram_rd_data),
        .wr       (drain_wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // A token read never collides with a write to the same entry
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr.en && ram_rd_en) |-> (ram_wr.addr != ram_rd_addr))
        else $error("token RAM read and write hit the same entry");

    // Scanner and drain never write the RAM in the same cycle
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(scan_wr.en && drain_wr.en))
        else $error("token RAM written from both sides");

    // Only identifiers and numbers are ever cut
    a_trunc_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[CHAR_W]) |->
            (m_tuser[2:0] == K_IDENT || m_tuser[2:0] == K_NUMBER))
        else $error("truncated flag on a token that cannot be cut");
`endif

endmodule

/* verif/lexical_token_scanner_unit_test.sv */
// Self-checking testbench for lexical_token_scanner_unit: a scripted opening, then random
// source text (tokens, comments, noise, end marks), each result checked against a predictor.
// Depends on lts_pkg and the scanner RTL; reads no files.
module lexical_token_scanner_unit_test;
    import lts_pkg::*;

    localparam int RANDOM_ITEMS   = 300;
    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES  = 40;

    // One expected token character
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  kwi;
        logic [7:0]  ch;
        logic        last;
        logic        trunc;
        logic        err;
    } token_char_t;

    localparam token_char_t NO_CHECK = '0;

    // One scripted input item; typed rows carry their single result
    typedef struct {
        logic [7:0]  ch;
        logic        eoi;
        logic        typed;
        token_char_t want;
    } script_row_t;

    typedef enum int {
        SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_CMP, SCAN_SLASH, SCAN_REMARK, SCAN_REMARK_STAR
    } scan_state_t;

    localparam int OPENING_ROWS = 26;

    script_row_t opening_script [OPENING_ROWS] = '{
        // keyword before any error
        '{"w", 1'b0, 1'b0, NO_CHECK}, '{"h", 1'b0, 1'b0, NO_CHECK},
        '{"i", 1'b0, 1'b0, NO_CHECK}, '{"l", 1'b0, 1'b0, NO_CHECK},
        '{"e", 1'b0, 1'b0, NO_CHECK}, '{" ", 1'b0, 1'b0, NO_CHECK},
        // byte extremes are error tokens, sticky flag rises on the first
        '{8'h00, 1'b0, 1'b1, '{K_ERROR, 3'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{K_ERROR, 3'd0, 8'hFF, 1'b1, 1'b0, 1'b1}},
        '{"+",   1'b0, 1'b1, '{K_DELIM, 3'd0, 8'h2B, 1'b1, 1'b0, 1'b1}},
        // number ended by a delimiter
        '{"1", 1'b0, 1'b0, NO_CHECK}, '{"2", 1'b0, 1'b0, NO_CHECK},
        '{";", 1'b0, 1'b0, NO_CHECK},
        // compare pair, then lone compare followed by a word
        '{">", 1'b0, 1'b0, NO_CHECK}, '{"=", 1'b0, 1'b0, NO_CHECK},
        '{"!", 1'b0, 1'b0, NO_CHECK}, '{"x", 1'b0, 1'b0, NO_CHECK},
        // slash as divide, then comment whose opening star does not close it
        '{"/", 1'b0, 1'b0, NO_CHECK}, '{"a", 1'b0, 1'b0, NO_CHECK},
        '{"/", 1'b0, 1'b0, NO_CHECK}, '{"*", 1'b0, 1'b0, NO_CHECK},
        '{"/", 1'b0, 1'b0, NO_CHECK}, '{"*", 1'b0, 1'b0, NO_CHECK},
        '{"/", 1'b0, 1'b0, NO_CHECK},
        // end of text inside an open comment
        '{"/", 1'b0, 1'b0, NO_CHECK}, '{"*", 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b1, 1'b0, NO_CHECK}
    };

    string kw_names [8] = '{"if", "else", "for", "while", "do", "int", "read", "write"};

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;

    // Predictor state
    scan_state_t scan_state = SCAN_IDLE;
    logic [7:0]  word_buf [MAX_TOKEN];
    int          word_len   = 0;
    logic [7:0]  held_cmp   = 8'h00;
    logic        word_cut   = 1'b0;
    logic        sticky_err = 1'b0;

    token_char_t pending_token_chars [$];
    int          items_sent  = 0;
    int          fail_count  = 0;
    int          sink_hold   = 0;
    logic        quiet_phase = 1'b0;

    lexical_token_scanner_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("lexical_token_scanner_unit_test: errors");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    task automatic push_char(input kind_t kind, input logic [2:0] kwi, input logic [7:0] ch,
                             input logic last, input logic trunc);
        token_char_t t;
        t.kind  = kind;
        t.kwi   = kwi;
        t.ch    = ch;
        t.last  = last;
        t.trunc = trunc;
        t.err   = sticky_err;
        pending_token_chars.push_back(t);
    endtask

    task automatic store_char(input logic [7:0] c);
        if (word_len < MAX_TOKEN) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            word_cut = 1'b1;
        end
    endtask

    // Emit the buffered word, classified as number, keyword or identifier
    task automatic emit_word();
        kind_t      kind;
        logic [2:0] kwi;
        logic       match;
        logic       found;
        kind  = (scan_state == SCAN_DIGITS) ? K_NUMBER : K_IDENT;
        kwi   = 3'd0;
        found = 1'b0;
        if (kind == K_IDENT && !word_cut) begin
            for (int k = 0; k < 8; k++) begin
                if (!found && kw_names[k].len() == word_len) begin
                    match = 1'b1;
                    for (int i = 0; i < word_len; i++) begin
                        if (word_buf[i] != kw_names[k][i]) match = 1'b0;
                    end
                    if (match) begin
                        found = 1'b1;
                        kind  = K_KEYWORD;
                        kwi   = 3'(k);
                    end
                end
            end
        end
        for (int i = 0; i < word_len; i++) begin
            push_char(kind, kwi, word_buf[i], i + 1 == word_len, word_cut);
        end
        word_len = 0;
        word_cut = 1'b0;
    endtask

    // Advance the predictor by one accepted item
    task automatic scan_byte(input logic [7:0] c, input logic eoi);
        if (eoi) begin
            case (scan_state)
                SCAN_WORD, SCAN_DIGITS: emit_word();
                SCAN_CMP:   push_char(K_DELIM, 3'd0, held_cmp, 1'b1, 1'b0);
                SCAN_SLASH: push_char(K_DELIM, 3'd0, "/", 1'b1, 1'b0);
                default: ;
            endcase
            scan_state = SCAN_IDLE;
            word_len   = 0;
            word_cut   = 1'b0;
            return;
        end

        // finish or extend the token in progress
        case (scan_state)
            SCAN_WORD: begin
                if (is_letter(c) || is_numeral(c)) begin
                    store_char(c);
                    return;
                end
                emit_word();
            end
            SCAN_DIGITS: begin
                if (is_numeral(c)) begin
                    store_char(c);
                    return;
                end
                emit_word();
            end
            SCAN_CMP: begin
                if (c == "=") begin
                    push_char(K_DELIM, 3'd0, held_cmp, 1'b0, 1'b0);
                    push_char(K_DELIM, 3'd0, "=", 1'b1, 1'b0);
                    scan_state = SCAN_IDLE;
                    return;
                end
                push_char(K_DELIM, 3'd0, held_cmp, 1'b1, 1'b0);
            end
            SCAN_SLASH: begin
                if (c == "*") begin
                    scan_state = SCAN_REMARK;
                    return;
                end
                push_char(K_DELIM, 3'd0, "/", 1'b1, 1'b0);
            end
            SCAN_REMARK: begin
                scan_state = (c == "*") ? SCAN_REMARK_STAR : SCAN_REMARK;
                return;
            end
            SCAN_REMARK_STAR: begin
                if (c == "/") scan_state = SCAN_IDLE;
                else if (c != "*") scan_state = SCAN_REMARK;
                return;
            end
            default: ;
        endcase

        // start a new token with this byte
        scan_state = SCAN_IDLE;
        word_len   = 0;
        word_cut   = 1'b0;
        if (c == 8'h20 || c == 8'h0A || c == 8'h09) begin
            // whitespace separates only
        end else if (is_letter(c)) begin
            store_char(c);
            scan_state = SCAN_WORD;
        end else if (is_numeral(c)) begin
            store_char(c);
            scan_state = SCAN_DIGITS;
        end else if (c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
                     c == "{" || c == "}" || c == ";" || c == "," || c == ":") begin
            push_char(K_DELIM, 3'd0, c, 1'b1, 1'b0);
        end else if (c == ">" || c == "<" || c == "=" || c == "!") begin
            held_cmp   = c;
            scan_state = SCAN_CMP;
        end else if (c == "/") begin
            scan_state = SCAN_SLASH;
        end else begin
            sticky_err = 1'b1;
            push_char(K_ERROR, 3'd0, c, 1'b1, 1'b0);
        end
    endtask

    // Drive one item, wait for its handshake, then predict its results
    task automatic send_item(input logic [7:0] c, input logic eoi, input logic typed,
                             input token_char_t want);
        int gap;
        int queued;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        queued = pending_token_chars.size();
        scan_byte(c, eoi);
        if (typed) begin
            while (pending_token_chars.size() > queued) void'(pending_token_chars.pop_back());
            pending_token_chars.push_back(want);
        end
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(c, 1'b0, 1'b0, NO_CHECK);
    endtask

    // Hold the sender until every expected character has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_token_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                    : 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] rand_numeral();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic int word_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
    endfunction

    // Send one random fragment of source text
    task automatic send_fragment();
        int    r;
        int    n;
        string kw;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            kw = kw_names[$urandom_range(0, 7)];
            for (int i = 0; i < kw.len(); i++) send_char(kw[i]);
            if ($urandom_range(0, 1)) send_char(pick_from(" \n\t"));
        end else if (r < 32) begin
            n = word_size();
            send_char(rand_letter());
            for (int i = 1; i < n; i++) begin
                send_char($urandom_range(0, 3) == 0 ? rand_numeral() : rand_letter());
            end
            if ($urandom_range(0, 1)) send_char(pick_from(" \n\t"));
        end else if (r < 42) begin
            n = word_size();
            for (int i = 0; i < n; i++) send_char(rand_numeral());
        end else if (r < 54) begin
            send_char(pick_from("+-*(){};,:"));
        end else if (r < 64) begin
            send_char(pick_from("><=!"));
            if ($urandom_range(0, 1)) send_char("=");
        end else if (r < 68) begin
            send_char("/");
        end else if (r < 76) begin
            send_char("/");
            send_char("*");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) send_char(pick_from("ab*/ 1="));
            if ($urandom_range(0, 3) != 0) begin
                send_char("*");
                send_char("/");
            end
        end else if (r < 88) begin
            send_char(pick_from(" \n\t"));
        end else if (r < 96) begin
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_CHECK);
        end
    endtask

    // Receiver with random stalls
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= quiet_phase ? 0 : pick_gap();
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge aclk) begin
        token_char_t exp_char;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_token_chars.size() == 0) begin
                $error("token_char: nothing expected, got %h", m_tdata[7:0]);
                fail_count++;
            end else begin
                exp_char = pending_token_chars.pop_front();
                if (m_tuser[2:0] !== exp_char.kind) begin
                    $error("kind: expected %0d, got %0d", exp_char.kind, m_tuser[2:0]);
                    fail_count++;
                end
                if (m_tuser[5:3] !== exp_char.kwi) begin
                    $error("keyword_index: expected %0d, got %0d", exp_char.kwi, m_tuser[5:3]);
                    fail_count++;
                end
                if (m_tdata[7:0] !== exp_char.ch) begin
                    $error("token_char: expected %h, got %h", exp_char.ch, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tlast !== exp_char.last) begin
                    $error("last: expected %b, got %b", exp_char.last, m_tlast);
                    fail_count++;
                end
                if (m_tdata[8] !== exp_char.trunc) begin
                    $error("truncated: expected %b, got %b", exp_char.trunc, m_tdata[8]);
                    fail_count++;
                end
                if (m_tdata[9] !== exp_char.err) begin
                    $error("error_seen: expected %b, got %b", exp_char.err, m_tdata[9]);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < OPENING_ROWS; i++) begin
            send_item(opening_script[i].ch, opening_script[i].eoi, opening_script[i].typed,
                      opening_script[i].want);
        end
        drain_results();

        while (items_sent < OPENING_ROWS + RANDOM_ITEMS) begin
            if (items_sent % 40 < 8) quiet_phase = ($urandom_range(0, 3) == 0);
            send_fragment();
            if (items_sent > OPENING_ROWS + RANDOM_ITEMS / 2 && $urandom_range(0, 49) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("lexical_token_scanner_unit_test: clean");
        end else begin
            $display("lexical_token_scanner_unit_test: errors");
        end
        $finish;
    end

endmodule

/* lexical_token_scanner_unit.f */
hdl/lts_pkg.sv
hdl/lts_ram.sv
hdl/lts_scanner.sv
hdl/lts_drain.sv
hdl/lexical_token_scanner_unit.sv
verif/lexical_token_scanner_unit_test.sv
